// ===== hw/rtl/intrusion_alarm_phase_controller_defines.svh =====
// assertion macros shared by the rtl
`ifndef INTRUSION_ALARM_PHASE_CONTROLLER_DEFINES_SVH
`define INTRUSION_ALARM_PHASE_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== hw/rtl/iapc_pkg.sv =====
package iapc_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_DOOR   = 2'd2;
    localparam logic [1:0] OP_CANCEL = 2'd3;

    // event codes of a result word
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_ARMED   = 3'd1;
    localparam logic [2:0] EV_DOOR    = 3'd2;
    localparam logic [2:0] EV_TRIG    = 3'd3;
    localparam logic [2:0] EV_TEMPDIS = 3'd4;
    localparam logic [2:0] EV_REARM   = 3'd5;

    // phase codes as reported
    localparam logic [2:0] PC_NONE     = 3'd0;
    localparam logic [2:0] PC_GRACE    = 3'd1;
    localparam logic [2:0] PC_WINDOW   = 3'd2;
    localparam logic [2:0] PC_COOLDOWN = 3'd3;
    localparam logic [2:0] PC_DISABLED = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_GRACE     = 3'd0;
    localparam logic [2:0] REG_WINDOW    = 3'd1;
    localparam logic [2:0] REG_COOLDOWN  = 3'd2;
    localparam logic [2:0] REG_DISABLE   = 3'd3;
    localparam logic [2:0] REG_LIMIT     = 3'd4;
    localparam logic [2:0] REG_STEALTH   = 3'd5;
    localparam logic [2:0] REG_ARMED_RST = 3'd6;

    // configuration reset values
    localparam logic [31:0] GRACE_RST    = 32'd30000;
    localparam logic [31:0] WINDOW_RST   = 32'd10000;
    localparam logic [31:0] COOLDOWN_RST = 32'd60000;
    localparam logic [31:0] DISABLE_RST  = 32'd3600000;
    localparam logic [7:0]  LIMIT_RST    = 8'd3;
    localparam logic        STEALTH_RST  = 1'b0;
    // reset value of the armed-after-reset register, which the armed flag takes
    localparam logic        ARMED_RST    = 1'b0;

    localparam logic [7:0]  COUNT_MAX    = 8'd255;

    // pending phase, one-hot
    typedef enum logic [4:0] {
        PH_NONE     = 5'b00001,
        PH_GRACE    = 5'b00010,
        PH_WINDOW   = 5'b00100,
        PH_COOLDOWN = 5'b01000,
        PH_DISABLED = 5'b10000
    } t_phase;

    typedef struct packed {
        logic        armed;
        logic        disabled;
        logic [7:0]  total;
        t_phase      phase;
        logic [31:0] countdown;
    } t_state;

    typedef struct packed {
        logic [31:0] grace;
        logic [31:0] window;
        logic [31:0] cooldown;
        logic [31:0] disable_len;
        logic [7:0]  limit;
        logic        stealth;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  event_code;
        logic        event_armed;
        logic        event_door;
        logic [7:0]  event_count;
        logic        beep_request;
        logic        is_armed;
        logic        is_temp_disabled;
        logic [2:0]  current_phase;
        logic [31:0] remaining_ticks;
    } t_result;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        code = PC_NONE;
        case (ph)
            PH_GRACE:    code = PC_GRACE;
            PH_WINDOW:   code = PC_WINDOW;
            PH_COOLDOWN: code = PC_COOLDOWN;
            PH_DISABLED: code = PC_DISABLED;
            default:     code = PC_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/iapc_step.sv =====
module iapc_step
    import iapc_pkg::*;
(
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    input  logic [1:0] i_operation,
    input  logic       i_door_open,
    output t_state     o_state,
    output t_result    o_result
);

    t_state  st;
    t_result res;

    always_comb begin
        st  = i_state;
        res = '0;
        res.event_code = EV_NONE;

        case (i_operation)
            // millisecond tick: count down, act on expiry
            OP_TICK: begin
                if (i_state.phase != PH_NONE) begin
                    if (i_state.countdown > 32'd1) begin
                        st.countdown = i_state.countdown - 32'd1;
                    end else begin
                        st.countdown = '0;
                        st.phase     = PH_NONE;
                        case (i_state.phase)
                            PH_GRACE: begin
                                res.event_code  = EV_DOOR;
                                res.event_armed = i_state.armed;
                                res.event_door  = i_door_open;
                                res.event_count = i_state.total;
                            end
                            PH_WINDOW: begin
                                if (i_state.total != COUNT_MAX) begin
                                    st.total = i_state.total + 8'd1;
                                end
                                res.event_code   = EV_TRIG;
                                res.event_armed  = 1'b1;
                                res.event_door   = 1'b1;
                                res.event_count  = st.total;
                                res.beep_request = ~i_cfg.stealth;
                                st.phase         = PH_COOLDOWN;
                                st.countdown     = i_cfg.cooldown;
                            end
                            PH_COOLDOWN: begin
                                if (i_state.total >= i_cfg.limit) begin
                                    st.disabled     = 1'b1;
                                    res.event_code  = EV_TEMPDIS;
                                    res.event_armed = i_state.armed;
                                    res.event_count = i_state.total;
                                    st.phase        = PH_DISABLED;
                                    st.countdown    = i_cfg.disable_len;
                                end
                            end
                            PH_DISABLED: begin
                                st.disabled     = 1'b0;
                                st.total        = '0;
                                res.event_code  = EV_REARM;
                                res.event_armed = i_state.armed;
                            end
                            default: begin
                                st.phase = PH_NONE;
                            end
                        endcase
                    end
                end
            end
            // toggle: arming starts grace, disarming drops the phase
            OP_TOGGLE: begin
                st.armed = ~i_state.armed;
                if (!i_state.armed) begin
                    res.event_code  = EV_ARMED;
                    res.event_armed = 1'b1;
                    res.event_door  = i_door_open;
                    st.phase        = PH_GRACE;
                    st.countdown    = i_cfg.grace;
                end else begin
                    st.phase     = PH_NONE;
                    st.countdown = '0;
                end
            end
            // door opened: (re)start the disarm window
            OP_DOOR: begin
                st.phase     = PH_WINDOW;
                st.countdown = i_cfg.window;
            end
            // cancel
            default: begin
                st.armed     = 1'b0;
                st.phase     = PH_NONE;
                st.countdown = '0;
            end
        endcase

        // status after the step
        res.is_armed         = st.armed;
        res.is_temp_disabled = st.disabled;
        res.current_phase    = phase_code(st.phase);
        res.remaining_ticks  = (st.phase == PH_NONE) ? 32'd0 : st.countdown;
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

// ===== hw/rtl/intrusion_alarm_phase_controller.sv =====
// Intrusion alarm phase controller. Takes one word per cycle (tick, toggle, door opened,
// cancel) and returns exactly one result word for each; a word passes the input register,
// then the result register, with the whole state update done by the step logic between them.
// Full rate is one word per clock; the only limit is the result register, which holds while
// the output is stalled and then stalls the input once the input register is also full.
// Configuration registers are written through a plain write port; the user must write them
// only while the block is idle (the block does not enforce it). Writing the armed-after-reset
// register has no effect: the armed flag always restarts from that register's reset value (0) at reset.
`include "intrusion_alarm_phase_controller_defines.svh"

module intrusion_alarm_phase_controller
    import iapc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic        i_door_open,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_code,
    output logic        o_event_armed,
    output logic        o_event_door,
    output logic [7:0]  o_event_count,
    output logic        o_beep_request,
    output logic        o_is_armed,
    output logic        o_is_temp_disabled,
    output logic [2:0]  o_current_phase,
    output logic [31:0] o_remaining_ticks,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_s1_valid;
    logic [1:0] r_s1_operation;
    logic       r_s1_door_open;
    logic       r_out_valid;
    logic       out_free;
    logic       s1_move;
    logic       in_acc;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grace       <= GRACE_RST;
            r_cfg.window      <= WINDOW_RST;
            r_cfg.cooldown    <= COOLDOWN_RST;
            r_cfg.disable_len <= DISABLE_RST;
            r_cfg.limit       <= LIMIT_RST;
            r_cfg.stealth     <= STEALTH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GRACE:    r_cfg.grace       <= i_cfg_data;
                REG_WINDOW:   r_cfg.window      <= i_cfg_data;
                REG_COOLDOWN: r_cfg.cooldown    <= i_cfg_data;
                REG_DISABLE:  r_cfg.disable_len <= i_cfg_data;
                REG_LIMIT:    r_cfg.limit       <= i_cfg_data[7:0];
                REG_STEALTH:  r_cfg.stealth     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // handshake between the two stages
    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_acc   = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc || o_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_operation <= i_operation;
            r_s1_door_open <= i_door_open;
        end
    end

    // step logic
    iapc_step u_step (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_operation (r_s1_operation),
        .i_door_open (r_s1_door_open),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // alarm state, advanced as a word moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.armed     <= ARMED_RST;
            r_state.disabled  <= 1'b0;
            r_state.total     <= '0;
            r_state.phase     <= PH_NONE;
            r_state.countdown <= '0;
        end else if (s1_move) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= s1_move || (r_out_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_result <= n_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_event_code       = r_result.event_code;
    assign o_event_armed      = r_result.event_armed;
    assign o_event_door       = r_result.event_door;
    assign o_event_count      = r_result.event_count;
    assign o_beep_request     = r_result.beep_request;
    assign o_is_armed         = r_result.is_armed;
    assign o_is_temp_disabled = r_result.is_temp_disabled;
    assign o_current_phase    = r_result.current_phase;
    assign o_remaining_ticks  = r_result.remaining_ticks;

    // checks
    `ASSERT_IMPLIES(a_idle_no_count, i_clk, i_rst_n, r_state.phase == PH_NONE, r_state.countdown == 32'd0)
    `ASSERT_IMPLIES(a_beep_on_trig, i_clk, i_rst_n, r_out_valid && o_beep_request, o_event_code == EV_TRIG)
    `ASSERT_NEXT(a_stall_holds_state, i_clk, i_rst_n, r_out_valid && i_stall, $stable(r_state.countdown) && $stable(r_state.total))

endmodule
